>>> rtl/core/chm_pkg.sv
// ---------------------------------------------------------------------------
// chm_pkg
// Shared types and constants for the chained hash map engine.
// ---------------------------------------------------------------------------
package chm_pkg;

    localparam int KEY_W    = 64;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = 10;
    localparam int TB_W     = 4;
    localparam int TB_MIN   = 1;
    localparam int TB_MAX   = 10;
    localparam int TB_RESET = 10;
    localparam int WIDE_W   = 17;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    localparam logic REG_TABLE_BITS = 1'b0;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_LOOKUP,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_HEAD,
        ST_ENTRY
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_item;

endpackage

>>> rtl/core/chm_front.sv
// ---------------------------------------------------------------------------
// chm_front
// Accepts items, decodes the operation and holds them in a two-deep queue.
// ---------------------------------------------------------------------------
module chm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_func,
    input  logic [chm_pkg::KEY_W-1:0]   i_key,
    input  logic [chm_pkg::VAL_W-1:0]   i_value,
    output logic                        o_q_valid,
    output chm_pkg::t_item              o_q_item,
    input  logic                        i_q_pop
);

    chm_pkg::t_item r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_fill;
    chm_pkg::t_op   dec_op;
    logic           push;

    always_comb begin
        unique case (i_func)
            chm_pkg::FUNC_INSERT: dec_op = chm_pkg::OP_INSERT;
            chm_pkg::FUNC_LOOKUP: dec_op = chm_pkg::OP_LOOKUP;
            chm_pkg::FUNC_CLEAR:  dec_op = chm_pkg::OP_CLEAR;
            default:              dec_op = chm_pkg::OP_NOP;
        endcase
    end

    assign o_stall   = (r_fill == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= '{op: dec_op, key: i_key, value: i_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= !r_wr_ptr;
            if (i_q_pop) r_rd_ptr <= !r_rd_ptr;
            case ({push, i_q_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> rtl/core/chm_back.sv
// ---------------------------------------------------------------------------
// chm_back
// Executes inserts, lookups and clears against head and entry memories.
// ---------------------------------------------------------------------------
module chm_back #(
    parameter int MAX_ENTRIES = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [chm_pkg::TB_W-1:0]         i_table_bits,
    input  logic                             i_q_valid,
    input  chm_pkg::t_item                   i_q_item,
    output logic                             o_q_pop,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_status,
    output logic [chm_pkg::IDX_W-1:0]        o_index,
    output logic [chm_pkg::VAL_W-1:0]        o_found_value
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CNTW = $clog2(MAX_ENTRIES + 1);
    localparam int VW   = (VALUE_BITS > chm_pkg::VAL_W) ? chm_pkg::VAL_W : VALUE_BITS;
    localparam logic [AW-1:0] LAST = AW'(MAX_ENTRIES - 1);

    // head and link words: {valid, entry index}
    logic [AW:0]                  m_head  [MAX_ENTRIES];
    logic [chm_pkg::KEY_W-1:0]    m_key   [MAX_ENTRIES];
    logic [VW-1:0]                m_val   [MAX_ENTRIES];
    logic [AW:0]                  m_link  [MAX_ENTRIES];

    chm_pkg::t_state              r_state;
    chm_pkg::t_state              n_state;
    logic [AW-1:0]                r_sw;
    logic                         r_sw_clr;
    logic [CNTW-1:0]              r_count;
    chm_pkg::t_op                 r_op;
    logic [chm_pkg::KEY_W-1:0]    r_key;
    logic [VW-1:0]                r_value;
    logic [AW-1:0]                r_slot;
    logic [AW-1:0]                r_cur;
    logic [AW:0]                  r_head_rd;
    logic [chm_pkg::KEY_W-1:0]    r_key_rd;
    logic [VW-1:0]                r_val_rd;
    logic [AW:0]                  r_link_rd;
    logic                         r_out_valid;
    logic [1:0]                   r_out_status;
    logic [AW-1:0]                r_out_index;
    logic [VW-1:0]                r_out_value;

    logic [chm_pkg::TB_W-1:0]     tb_eff;
    logic [chm_pkg::WIDE_W-1:0]   cap_raw;
    logic [chm_pkg::WIDE_W-1:0]   cap;
    logic [chm_pkg::WIDE_W-1:0]   cap_m1;
    logic [AW-1:0]                q_slot;
    logic                         full;
    logic                         out_free;
    logic                         pop;
    logic                         ent_wr;
    logic                         head_wr;
    logic [AW-1:0]                head_wr_addr;
    logic [AW:0]                  head_wr_data;
    logic [AW-1:0]                ent_rd_addr;
    logic                         res_fire;
    logic [1:0]                   res_status;
    logic [AW-1:0]                res_index;
    logic [VW-1:0]                res_value;
    logic [AW-1:0]                pos;
    logic                         key_hit;
    logic [chm_pkg::WIDE_W-1:0]   idx_wide;

    always_comb begin
        if (i_table_bits < chm_pkg::TB_W'(chm_pkg::TB_MIN)) begin
            tb_eff = chm_pkg::TB_W'(chm_pkg::TB_MIN);
        end else if (i_table_bits > chm_pkg::TB_W'(chm_pkg::TB_MAX)) begin
            tb_eff = chm_pkg::TB_W'(chm_pkg::TB_MAX);
        end else begin
            tb_eff = i_table_bits;
        end
        cap_raw = chm_pkg::WIDE_W'(1) << tb_eff;
        cap     = (cap_raw > chm_pkg::WIDE_W'(MAX_ENTRIES)) ?
                  chm_pkg::WIDE_W'(MAX_ENTRIES) : cap_raw;
        cap_m1  = cap - chm_pkg::WIDE_W'(1);
    end

    assign q_slot   = i_q_item.key[AW-1:0] & cap_m1[AW-1:0];
    assign full     = chm_pkg::WIDE_W'(r_count) >= cap;
    assign out_free = !r_out_valid || !i_stall;
    assign pos      = r_count[AW-1:0];
    assign key_hit  = (r_key_rd == r_key);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chm_pkg::ST_SWEEP: begin
                if (r_sw == LAST) n_state = chm_pkg::ST_IDLE;
            end
            chm_pkg::ST_IDLE: begin
                if (pop) begin
                    case (i_q_item.op)
                        chm_pkg::OP_CLEAR:  n_state = chm_pkg::ST_SWEEP;
                        chm_pkg::OP_LOOKUP: n_state = chm_pkg::ST_HEAD;
                        chm_pkg::OP_INSERT: n_state = full ? chm_pkg::ST_IDLE
                                                           : chm_pkg::ST_HEAD;
                        default:            n_state = chm_pkg::ST_IDLE;
                    endcase
                end
            end
            chm_pkg::ST_HEAD: begin
                if (r_op == chm_pkg::OP_LOOKUP && r_head_rd[AW]) begin
                    n_state = chm_pkg::ST_ENTRY;
                end else begin
                    n_state = chm_pkg::ST_IDLE;
                end
            end
            chm_pkg::ST_ENTRY: begin
                if (key_hit || !r_link_rd[AW]) n_state = chm_pkg::ST_IDLE;
            end
            default: n_state = chm_pkg::ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        pop          = 1'b0;
        ent_wr       = 1'b0;
        head_wr      = 1'b0;
        head_wr_addr = r_sw;
        head_wr_data = '0;
        ent_rd_addr  = r_cur;
        res_fire     = 1'b0;
        res_status   = chm_pkg::STATUS_DONE;
        res_index    = '0;
        res_value    = '0;
        unique case (r_state)
            chm_pkg::ST_SWEEP: begin
                head_wr = 1'b1;
                if (r_sw == LAST && r_sw_clr) res_fire = 1'b1;
            end
            chm_pkg::ST_IDLE: begin
                pop = i_q_valid && out_free;
                if (pop) begin
                    if (i_q_item.op == chm_pkg::OP_NOP) begin
                        res_fire = 1'b1;
                    end else if (i_q_item.op == chm_pkg::OP_INSERT && full) begin
                        res_fire   = 1'b1;
                        res_status = chm_pkg::STATUS_FULL;
                    end
                end
            end
            chm_pkg::ST_HEAD: begin
                if (r_op == chm_pkg::OP_INSERT) begin
                    ent_wr       = 1'b1;
                    head_wr      = 1'b1;
                    head_wr_addr = r_slot;
                    head_wr_data = {1'b1, pos};
                    res_fire     = 1'b1;
                    res_index    = pos;
                end else if (r_head_rd[AW]) begin
                    ent_rd_addr = r_head_rd[AW-1:0];
                end else begin
                    res_fire   = 1'b1;
                    res_status = chm_pkg::STATUS_NOT_FOUND;
                end
            end
            chm_pkg::ST_ENTRY: begin
                if (key_hit) begin
                    res_fire  = 1'b1;
                    res_index = r_cur;
                    res_value = r_val_rd;
                end else if (r_link_rd[AW]) begin
                    ent_rd_addr = r_link_rd[AW-1:0];
                end else begin
                    res_fire   = 1'b1;
                    res_status = chm_pkg::STATUS_NOT_FOUND;
                end
            end
            default: ;
        endcase
    end

    assign o_q_pop = pop;

    // memories
    always_ff @(posedge i_clk) begin
        if (head_wr) m_head[head_wr_addr] <= head_wr_data;
        r_head_rd <= m_head[q_slot];
    end

    always_ff @(posedge i_clk) begin
        if (ent_wr) begin
            m_key[pos]  <= r_key;
            m_val[pos]  <= r_value;
            m_link[pos] <= r_head_rd;
        end
        r_key_rd  <= m_key[ent_rd_addr];
        r_val_rd  <= m_val[ent_rd_addr];
        r_link_rd <= m_link[ent_rd_addr];
    end

    // item payload and walk pointer
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_op    <= i_q_item.op;
            r_key   <= i_q_item.key;
            r_value <= i_q_item.value[VW-1:0];
            r_slot  <= q_slot;
        end
        r_cur <= ent_rd_addr;
        if (res_fire) begin
            r_out_status <= res_status;
            r_out_index  <= res_index;
            r_out_value  <= res_value;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chm_pkg::ST_SWEEP;
            r_sw        <= '0;
            r_sw_clr    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == chm_pkg::ST_SWEEP) r_sw <= (r_sw == LAST) ? '0 : r_sw + AW'(1);
            if (pop && i_q_item.op == chm_pkg::OP_CLEAR) begin
                r_sw_clr <= 1'b1;
                r_count  <= '0;
            end
            if (ent_wr) r_count <= r_count + CNTW'(1);
            if (res_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign idx_wide      = chm_pkg::WIDE_W'(r_out_index);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_index       = idx_wide[chm_pkg::IDX_W-1:0];
    assign o_found_value = chm_pkg::VAL_W'(r_out_value);

endmodule

>>> rtl/core/chained_hash_map_engine_core.sv
// ---------------------------------------------------------------------------
// chained_hash_map_engine_core
// Insert-only hash map with separate chaining: a two-deep front queue feeds
// an engine that walks head and entry memories one access per cycle.
// ---------------------------------------------------------------------------
// Steps: insert reads the head, then writes entry and head; lookup reads the
//   head, then one entry per step to the match; full/unused op ends at pop.
// Throughput: one item at a time; set by the single read port of the entry
//   memories, which the chain walk uses once per cycle.
// Reset: synchronous, active low. After reset, and on a clear, the engine
//   sweeps the head memory before taking an item; table_bits resets
//   to 10 and config writes are taken during the sweep.
// ---------------------------------------------------------------------------
module chained_hash_map_engine_core #(
    parameter int MAX_ENTRIES = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item in
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_func,
    input  logic signed [63:0]           i_key,
    input  logic [31:0]                  i_value,
    // item out
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [9:0]                   o_index,
    output logic [31:0]                  o_found_value,
    // config
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [chm_pkg::TB_W-1:0] r_table_bits;
    logic                     q_valid;
    chm_pkg::t_item           q_item;
    logic                     q_pop;

    // single register at byte 0; word index is paddr[2]
    assign pready = 1'b1;
    assign prdata = (paddr[2] == chm_pkg::REG_TABLE_BITS) ?
                    {{(32 - chm_pkg::TB_W){1'b0}}, r_table_bits} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_bits <= chm_pkg::TB_W'(chm_pkg::TB_RESET);
        end else if (psel && penable && pwrite && paddr[2] == chm_pkg::REG_TABLE_BITS) begin
            r_table_bits <= pwdata[chm_pkg::TB_W-1:0];
        end
    end

    chm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_func    (i_func),
        .i_key     (i_key),
        .i_value   (i_value),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    chm_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_table_bits  (r_table_bits),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_index       (o_index),
        .o_found_value (o_found_value)
    );

endmodule
